// ===== rtl/lgs_pkg.sv =====
// Shared constants, register codes and inter-stage structs for the
// life generation stream block. No dependencies.
package lgs_pkg;

  localparam int MAX_WIDTH = 256;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 12;
  localparam int COL_W     = 8;
  localparam int GW_W      = 9;
  localparam int CFG_W     = 12;
  localparam int IDX_W     = 1;
  localparam int STORE_W   = 2;
  localparam int MIN_SIZE  = 3;

  localparam logic [GW_W-1:0]  GRID_WIDTH_RST  = GW_W'(182);
  localparam logic [ROW_W-1:0] GRID_HEIGHT_RST = ROW_W'(62);

  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef enum logic [IDX_W-1:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } lgs_reg_t;

  // Item held between the raster stage and the rule stage.
  typedef struct packed {
    logic               valid;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row_last;
    logic [COL_W-1:0]   col_last;
    logic               alive_now;
    logic               fwd;
    logic [STORE_W-1:0] fwd_data;
    logic               has_inner;
    logic               has_rowend;
    logic               has_lastrow;
    logic               inner_live;
    logic               done;
  } lgs_item_t;

  // Line store write, {older, newer} per column.
  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  addr;
    logic [STORE_W-1:0] data;
  } lgs_wr_t;

  // Up to three results caused by one item; mask bit per result slot.
  typedef struct packed {
    logic [2:0]       mask;
    logic             alive;
    logic [ROW_W-1:0] row_m1;
    logic [COL_W-1:0] col_m1;
    logic [ROW_W-1:0] row_last;
    logic [COL_W-1:0] col_last;
    logic [COL_W-1:0] col;
    logic             done;
  } lgs_set_t;

endpackage

// ===== rtl/lgs_cell_if.sv =====
// Input channel: one grid cell per beat.
// No dependencies.
interface lgs_cell_if;
  logic valid;
  logic ready;
  logic cell_alive;
  logic frame_start;

  modport source (output valid, output cell_alive, output frame_start, input ready);
  modport sink (input valid, input cell_alive, input frame_start, output ready);
endinterface

// ===== rtl/lgs_result_if.sv =====
// Output channel: one next-generation cell per beat.
// Widths fixed to 12-bit row and 8-bit column.
interface lgs_result_if;
  logic        valid;
  logic        ready;
  logic        next_alive;
  logic [11:0] out_row;
  logic [7:0]  out_col;
  logic        last;
  logic        frame_done;

  modport source (output valid, output next_alive, output out_row, output out_col,
                  output last, output frame_done, input ready);
  modport sink (input valid, input next_alive, input out_row, input out_col,
                input last, input frame_done, output ready);
endinterface

// ===== rtl/lgs_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module lgs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/lgs_raster.sv =====
// Size registers, row/column counters and the input item register.
// Depends on lgs_pkg.
module lgs_raster (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [lgs_pkg::IDX_W-1:0]  cfg_index,
  input  logic [lgs_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       in_valid,
  input  logic                       cell_alive,
  input  logic                       frame_start,
  output logic                       in_ready,
  input  logic                       advance,
  input  lgs_pkg::lgs_wr_t           wr,
  output logic                       rd_en,
  output logic [lgs_pkg::ADDR_W-1:0] rd_addr,
  output lgs_pkg::lgs_item_t         item
);
  import lgs_pkg::*;

  logic [GW_W-1:0]  grid_width;
  logic [ROW_W-1:0] grid_height;
  logic [GW_W-1:0]  w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [COL_W-1:0] col_last;
  logic [ROW_W-1:0] row_last;
  logic [ROW_W-1:0] row_count, row_count_next;
  logic [COL_W-1:0] col_count, col_count_next;
  logic [ROW_W-1:0] r0, r1, r;
  logic [COL_W-1:0] c0, c;
  logic             accept;
  lgs_item_t        item_next;

  assign accept   = in_valid && in_ready;
  assign in_ready = !item.valid || advance;
  assign rd_en    = accept;
  assign rd_addr  = ADDR_W'(c);

  always_comb begin
    if (grid_width < GW_W'(MIN_SIZE)) begin
      w_eff = GW_W'(MIN_SIZE);
    end else if (grid_width > GW_W'(MAX_WIDTH)) begin
      w_eff = GW_W'(MAX_WIDTH);
    end else begin
      w_eff = grid_width;
    end
    h_eff    = (grid_height < ROW_W'(MIN_SIZE)) ? ROW_W'(MIN_SIZE) : grid_height;
    col_last = COL_W'(w_eff - GW_W'(1));
    row_last = h_eff - ROW_W'(1);

    r0 = frame_start ? '0 : row_count;
    c0 = frame_start ? '0 : col_count;
    // size shrank under the counters: wrap
    if ({1'b0, c0} >= w_eff) begin
      c  = '0;
      r1 = r0 + ROW_W'(1);
    end else begin
      c  = c0;
      r1 = r0;
    end
    r = (r1 >= h_eff) ? '0 : r1;

    if (c == col_last) begin
      col_count_next = '0;
      row_count_next = (r >= row_last) ? '0 : r + ROW_W'(1);
    end else begin
      col_count_next = c + COL_W'(1);
      row_count_next = r;
    end

    item_next.valid       = 1'b1;
    item_next.row         = r;
    item_next.col         = c;
    item_next.row_last    = row_last;
    item_next.col_last    = col_last;
    item_next.alive_now   = cell_alive;
    // write of the rule stage lands on the column being read this edge
    item_next.fwd         = wr.we && (wr.addr == rd_addr);
    item_next.fwd_data    = wr.data;
    item_next.has_inner   = (r != '0) && (c != '0);
    item_next.has_rowend  = (r != '0) && (c == col_last);
    item_next.has_lastrow = (r == row_last);
    item_next.inner_live  = (r >= ROW_W'(2)) && (c >= COL_W'(2));
    item_next.done        = (c == col_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_WIDTH_RST;
      grid_height <= GRID_HEIGHT_RST;
      row_count   <= '0;
      col_count   <= '0;
      item.valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_GRID_WIDTH:  grid_width  <= cfg_data[GW_W-1:0];
          REG_GRID_HEIGHT: grid_height <= cfg_data[ROW_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        row_count <= row_count_next;
        col_count <= col_count_next;
        item      <= item_next;
      end else if (advance) begin
        item.valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/lgs_rule.sv =====
// 3x3 window, line store write-back and the B3/S23 decision.
// Depends on lgs_pkg.
module lgs_rule (
  input  logic                        clk,
  input  logic                        rst,
  input  lgs_pkg::lgs_item_t          item,
  input  logic [lgs_pkg::STORE_W-1:0] rdata,
  input  logic                        advance,
  output lgs_pkg::lgs_wr_t            wr,
  output lgs_pkg::lgs_set_t           set
);
  import lgs_pkg::*;

  logic [8:0]         window, window_next;
  logic [STORE_W-1:0] stored;
  logic [2:0]         new_col;
  logic [3:0]         cnt;
  logic               older, newer;

  assign stored = item.fwd ? item.fwd_data : rdata;
  assign older  = stored[1];
  assign newer  = stored[0];
  assign new_col = {item.alive_now, newer, older};

  assign wr.we   = advance;
  assign wr.addr = ADDR_W'(item.col);
  assign wr.data = {newer, item.alive_now};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      window_next[i*3]     = window[i*3+1];
      window_next[i*3 + 1] = window[i*3+2];
      window_next[i*3 + 2] = new_col[i];
    end
    cnt = '0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4) begin
        cnt = cnt + 4'(window_next[k]);
      end
    end
  end

  always_comb begin
    set.mask     = {item.has_lastrow, item.has_rowend, item.has_inner};
    set.alive    = item.inner_live &&
                   ((cnt == BIRTH_COUNT) || ((cnt == SURVIVE_COUNT) && window_next[4]));
    set.row_m1   = item.row - ROW_W'(1);
    set.col_m1   = item.col - COL_W'(1);
    set.row_last = item.row_last;
    set.col_last = item.col_last;
    set.col      = item.col;
    set.done     = item.done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (advance) begin
      window <= window_next;
    end
  end

endmodule

// ===== rtl/lgs_out.sv =====
// Result register: holds the results of one item and sends them one beat
// at a time. Depends on lgs_pkg.
module lgs_out (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     set_valid,
  input  lgs_pkg::lgs_set_t        set,
  output logic                     can_load,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic                     next_alive,
  output logic [lgs_pkg::ROW_W-1:0] out_row,
  output logic [lgs_pkg::COL_W-1:0] out_col,
  output logic                     last,
  output logic                     frame_done
);
  import lgs_pkg::*;

  logic [2:0] rem;
  lgs_set_t   hold;
  logic       single;

  assign single    = (rem & (rem - 3'd1)) == 3'd0;
  assign out_valid = rem != 3'd0;
  assign last      = out_valid && single;
  assign can_load  = !out_valid || (out_ready && single);

  always_comb begin
    next_alive = rem[0] && hold.alive;
    out_row    = (rem[0] || rem[1]) ? hold.row_m1 : hold.row_last;
    if (rem[0]) begin
      out_col = hold.col_m1;
    end else if (rem[1]) begin
      out_col = hold.col_last;
    end else begin
      out_col = hold.col;
    end
    frame_done = !rem[0] && !rem[1] && hold.done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (can_load) begin
      rem <= set_valid ? set.mask : 3'd0;
    end else if (out_ready) begin
      rem <= rem & (rem - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (can_load) begin
      hold <= set;
    end
  end

endmodule

// ===== rtl/life_generation_stream_top.sv =====
// Life generation stream: B3/S23 next generation of a raster cell stream.
// Channel "cells" takes one cell per beat in raster order; frame_start on a
// beat restarts the grid at row 0, column 0. Channel "results" gives the
// next state of each cell with its row and column; last marks the final
// beat caused by one input, frame_done the bottom right cell. The border
// ring is always dead. Result for (r-1, c-1) follows input (r, c).
// Size registers are written through cfg_write/cfg_index/cfg_data; the user
// must do so only while idle, not enforced by the block. Inputs pass the
// item, then the result register. One input per cycle unless results stall;
// last-row inputs cause two results each (one at column 0, three at its end),
// and the result register sends one beat per cycle while results are ready,
// so inputs wait. Two line stores share one 256 x 2 RAM with a registered
// read issued at input acceptance; a same-column write in the same cycle is
// bypassed. Reset (synchronous) clears counters, window and valid state and
// loads width 182, height 62; RAM contents stay unknown until written.
// A stall on results holds the result register; the input stage keeps one
// more item and drops ready until the result register can reload.
// Depends on lgs_pkg, lgs_cell_if, lgs_result_if, lgs_ram, lgs_raster,
// lgs_rule and lgs_out.
module life_generation_stream_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [lgs_pkg::IDX_W-1:0] cfg_index,
  input  logic [lgs_pkg::CFG_W-1:0] cfg_data,
  lgs_cell_if.sink                  cells,
  lgs_result_if.source              results
);
  import lgs_pkg::*;

  lgs_item_t          item;
  lgs_wr_t            wr;
  lgs_set_t           set;
  logic               advance;
  logic               can_load;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [STORE_W-1:0] rdata;

  assign advance = item.valid && can_load;

  lgs_raster u_raster (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (cells.valid),
    .cell_alive  (cells.cell_alive),
    .frame_start (cells.frame_start),
    .in_ready    (cells.ready),
    .advance     (advance),
    .wr          (wr),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .item        (item)
  );

  lgs_ram #(
    .WIDTH (STORE_W),
    .DEPTH (MAX_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  lgs_rule u_rule (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .rdata   (rdata),
    .advance (advance),
    .wr      (wr),
    .set     (set)
  );

  lgs_out u_out (
    .clk        (clk),
    .rst        (rst),
    .set_valid  (item.valid),
    .set        (set),
    .can_load   (can_load),
    .out_ready  (results.ready),
    .out_valid  (results.valid),
    .next_alive (results.next_alive),
    .out_row    (results.out_row),
    .out_col    (results.out_col),
    .last       (results.last),
    .frame_done (results.frame_done)
  );

endmodule
